// ===== rtl/core/thick_line_rasterizer_core_assert.svh =====
// Assertion macros shared by the thick line rasterizer modules.
`ifndef THICK_LINE_RASTERIZER_CORE_ASSERT_SVH
`define THICK_LINE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TLR_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rasterizer check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rasterizer sequencing check failed");

`endif

// ===== rtl/core/tlr_pkg.sv =====
// Shared types, widths and codes of the thick line rasterizer.
package tlr_pkg;

  // Fixed field widths.
  localparam int COORD_BITS     = 16;
  localparam int INK_BITS       = 32;
  localparam int WEIGHT_BITS    = 4;
  localparam int OUT_COORD_BITS = 12;
  localparam int DIM_REG_BITS   = 13;

  // Internal widths: current point, pen pixel and error term.
  localparam int CUR_BITS = COORD_BITS + 1;
  localparam int PIX_BITS = CUR_BITS + 1;
  localparam int ERR_BITS = COORD_BITS + 4;

  // Default values of the top-level parameters.
  localparam int DEF_MAX_WEIGHT = 8;
  localparam int DEF_MAX_DIM    = 4096;

  // Configuration port.
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic REG_CANVAS_WIDTH  = 1'b0;
  localparam logic REG_CANVAS_HEIGHT = 1'b1;
  localparam int RST_CANVAS_WIDTH  = 1024;
  localparam int RST_CANVAS_HEIGHT = 768;

  // Opcodes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Input word.
  typedef struct packed {
    logic                          opcode;
    logic signed [COORD_BITS-1:0]  first_x;
    logic signed [COORD_BITS-1:0]  first_y;
    logic signed [COORD_BITS-1:0]  second_x;
    logic signed [COORD_BITS-1:0]  second_y;
    logic [INK_BITS-1:0]           ink;
    logic [WEIGHT_BITS-1:0]        pen_weight;
  } req_t;

  // Output word.
  typedef struct packed {
    logic [OUT_COORD_BITS-1:0] pixel_x;
    logic [OUT_COORD_BITS-1:0] pixel_y;
    logic [INK_BITS-1:0]       pixel_ink;
    logic                      write_enable;
    logic                      last_of_point;
    logic                      line_done;
  } pix_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic diff;
    logic abs_dx;
    logic major;
    logic load;
    logic advance;
    logic pen_init;
    logic emit;
    logic emit_null;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic line_active;
    logic pen_end;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/tlr_cfg.sv =====
// Canvas size registers with their APB-style access port.
module tlr_cfg import tlr_pkg::*; #(
  parameter int MAX_DIM  = DEF_MAX_DIM,
  parameter int EXT_BITS = $clog2(MAX_DIM + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [EXT_BITS-1:0]      ext_w,
  output logic [EXT_BITS-1:0]      ext_h
);

  localparam logic [EXT_BITS-1:0] EXT_MAX = EXT_BITS'(MAX_DIM);
  localparam logic [EXT_BITS-1:0] EXT_W_RST =
    EXT_BITS'((RST_CANVAS_WIDTH > MAX_DIM) ? MAX_DIM : RST_CANVAS_WIDTH);
  localparam logic [EXT_BITS-1:0] EXT_H_RST =
    EXT_BITS'((RST_CANVAS_HEIGHT > MAX_DIM) ? MAX_DIM : RST_CANVAS_HEIGHT);

  logic [DIM_REG_BITS-1:0] canvas_width;
  logic [DIM_REG_BITS-1:0] canvas_height;
  logic [DIM_REG_BITS-1:0] wr_value;
  logic [EXT_BITS-1:0]     wr_extent;
  logic                    wr_en;
  logic                    reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_BITS-1];
  assign wr_en     = psel && penable && pwrite && pready;
  assign wr_value  = pwdata[DIM_REG_BITS-1:0];

  // The usable extent saturates at the largest supported canvas.
  assign wr_extent = (int'(wr_value) > MAX_DIM) ? EXT_MAX : EXT_BITS'(wr_value);

  // Register writes keep both the raw value and its saturated extent.
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= DIM_REG_BITS'(RST_CANVAS_WIDTH);
      canvas_height <= DIM_REG_BITS'(RST_CANVAS_HEIGHT);
      ext_w         <= EXT_W_RST;
      ext_h         <= EXT_H_RST;
    end else if (wr_en) begin
      if (reg_index == REG_CANVAS_WIDTH) begin
        canvas_width <= wr_value;
        ext_w        <= wr_extent;
      end else begin
        canvas_height <= wr_value;
        ext_h         <= wr_extent;
      end
    end
  end

  // Read data returns the register as written.
  assign prdata = (reg_index == REG_CANVAS_HEIGHT) ? APB_DATA_BITS'(canvas_height)
                                                   : APB_DATA_BITS'(canvas_width);

endmodule

// ===== rtl/core/tlr_ctrl.sv =====
// Sequencing state machine of the thick line rasterizer.
`include "thick_line_rasterizer_core_assert.svh"
module tlr_ctrl import tlr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DIFF    = 4'd1;
  localparam logic [3:0] S_ABS     = 4'd2;
  localparam logic [3:0] S_MAJOR   = 4'd3;
  localparam logic [3:0] S_LOAD    = 4'd4;
  localparam logic [3:0] S_ADVANCE = 4'd5;
  localparam logic [3:0] S_PEN     = 4'd6;
  localparam logic [3:0] S_EMIT    = 4'd7;
  localparam logic [3:0] S_NULL    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // A new word is taken only between items.
  assign req_stall = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.opcode == OP_START) begin
            cmd.load_in = 1'b1;
            state_next  = S_DIFF;
          end else if (sts.line_active) begin
            state_next = S_ADVANCE;
          end else begin
            state_next = S_NULL;
          end
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_ABS;
      end
      S_ABS: begin
        cmd.abs_dx = 1'b1;
        state_next = S_MAJOR;
      end
      S_MAJOR: begin
        cmd.major  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_PEN;
      end
      S_ADVANCE: begin
        cmd.advance = 1'b1;
        state_next  = S_PEN;
      end
      S_PEN: begin
        cmd.pen_init = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.pen_end) begin
            state_next = S_IDLE;
          end
        end
      end
      S_NULL: begin
        if (sts.out_free) begin
          cmd.emit_null = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `TLR_ASSERT_HOLDS(a_emit_has_room, cmd.emit || cmd.emit_null, sts.out_free)
  `TLR_ASSERT_NEXT(a_start_enters_setup, state == S_IDLE && req_valid && req.opcode == OP_START, state == S_DIFF)

endmodule

// ===== rtl/core/tlr_datapath.sv =====
// Line setup, Bresenham stepping, pen sweep, clipping and output register.
`include "thick_line_rasterizer_core_assert.svh"
module tlr_datapath import tlr_pkg::*; #(
  parameter int MAX_WEIGHT = DEF_MAX_WEIGHT,
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int EXT_BITS   = $clog2(MAX_DIM + 1),
  parameter int PEN_BITS   = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  req_t                req,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [EXT_BITS-1:0] ext_w,
  input  logic [EXT_BITS-1:0] ext_h,
  output logic                pix_valid,
  input  logic                pix_stall,
  output pix_t                pix
);

  localparam logic [WEIGHT_BITS-1:0] WMAX = WEIGHT_BITS'(MAX_WEIGHT);
  localparam logic [WEIGHT_BITS-1:0] WONE = WEIGHT_BITS'(1);

  // Setup registers.
  logic [CUR_BITS-1:0] a_x, a_y, b_x, b_y;
  logic [CUR_BITS-1:0] d_x, d_y;
  logic [CUR_BITS-1:0] maj_len, min_len;

  // Line state.
  logic [CUR_BITS-1:0] cur_x, cur_y;
  logic [ERR_BITS-1:0] error_term, minor_increment, both_increment;
  logic [CUR_BITS-1:0] steps_left;
  logic                x_major, x_step_negative, line_active;
  logic [INK_BITS-1:0] held_ink;
  logic [PEN_BITS-1:0] pen_half, pen_last;

  // Pen sweep.
  logic [PIX_BITS-1:0] pen_x0, pen_x, pen_y;
  logic [PEN_BITS-1:0] col, row;

  // Combinational helpers.
  logic                   swap;
  logic [WEIGHT_BITS-1:0] wgt, half4, last4;
  logic [CUR_BITS-1:0]    fx, fy, sx, sy;
  logic [ERR_BITS-1:0]    maj_e, min2, maj2;
  logic [CUR_BITS-1:0]    x_inc;
  logic                   on_canvas;
  logic                   out_free;
  pix_t                   pix_next;

  // Endpoints sign-extended and ordered by y.
  assign fx   = {req.first_x[COORD_BITS-1], req.first_x};
  assign fy   = {req.first_y[COORD_BITS-1], req.first_y};
  assign sx   = {req.second_x[COORD_BITS-1], req.second_x};
  assign sy   = {req.second_y[COORD_BITS-1], req.second_y};
  assign swap = $signed(req.first_y) > $signed(req.second_y);

  // Weight zero is one, weights beyond the maximum saturate.
  assign wgt   = (req.pen_weight == '0) ? WONE :
                 ((req.pen_weight > WMAX) ? WMAX : req.pen_weight);
  assign half4 = wgt >> 1;
  assign last4 = (half4 == '0) ? '0 : ((half4 << 1) - WONE);

  // Accept a start word.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_x      <= swap ? sx : fx;
      a_y      <= swap ? sy : fy;
      b_x      <= swap ? fx : sx;
      b_y      <= swap ? fy : sy;
      held_ink <= req.ink;
      pen_half <= PEN_BITS'(half4);
      pen_last <= PEN_BITS'(last4);
    end
  end

  // Differences, absolute dx and major axis selection, one per cycle.
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      d_x <= b_x - a_x;
      d_y <= b_y - a_y;
    end else if (cmd.abs_dx) begin
      x_step_negative <= d_x[CUR_BITS-1] || (d_x == '0);
      d_x             <= d_x[CUR_BITS-1] ? (~d_x + CUR_BITS'(1)) : d_x;
    end
    if (cmd.major) begin
      x_major <= d_x > d_y;
      maj_len <= (d_x > d_y) ? d_x : d_y;
      min_len <= (d_x > d_y) ? d_y : d_x;
    end
  end

  assign maj_e = ERR_BITS'(maj_len);
  assign maj2  = maj_e << 1;
  assign min2  = ERR_BITS'(min_len) << 1;
  assign x_inc = x_step_negative ? '1 : CUR_BITS'(1);

  // Line load and one Bresenham step.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (cmd.load) begin
      line_active <= (maj_len != '0);
    end else if (cmd.advance) begin
      line_active <= (steps_left != CUR_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      minor_increment <= min2;
      both_increment  <= min2 - maj2;
      error_term      <= min2 - maj_e;
      steps_left      <= maj_len;
      cur_x           <= a_x;
      cur_y           <= a_y;
    end else if (cmd.advance) begin
      steps_left <= steps_left - CUR_BITS'(1);
      error_term <= error_term + (error_term[ERR_BITS-1] ? minor_increment
                                                         : both_increment);
      if (x_major) begin
        cur_x <= cur_x + x_inc;
        if (!error_term[ERR_BITS-1]) begin
          cur_y <= cur_y + CUR_BITS'(1);
        end
      end else begin
        cur_y <= cur_y + CUR_BITS'(1);
        if (!error_term[ERR_BITS-1]) begin
          cur_x <= cur_x + x_inc;
        end
      end
    end
  end

  // Pen square sweep, row by row, left to right.
  always_ff @(posedge clk) begin
    if (cmd.pen_init) begin
      pen_x0 <= {cur_x[CUR_BITS-1], cur_x} - PIX_BITS'(pen_half);
      pen_x  <= {cur_x[CUR_BITS-1], cur_x} - PIX_BITS'(pen_half);
      pen_y  <= {cur_y[CUR_BITS-1], cur_y} - PIX_BITS'(pen_half);
      col    <= '0;
      row    <= '0;
    end else if (cmd.emit) begin
      if (col == pen_last) begin
        col   <= '0;
        row   <= row + PEN_BITS'(1);
        pen_x <= pen_x0;
        pen_y <= pen_y + PIX_BITS'(1);
      end else begin
        col   <= col + PEN_BITS'(1);
        pen_x <= pen_x + PIX_BITS'(1);
      end
    end
  end

  // Clipping against the canvas.
  assign on_canvas = !pen_x[PIX_BITS-1] && (pen_x < PIX_BITS'(ext_w)) &&
                     !pen_y[PIX_BITS-1] && (pen_y < PIX_BITS'(ext_h));

  // Next output word.
  always_comb begin
    pix_next = '0;
    if (cmd.emit) begin
      pix_next.pixel_x       = on_canvas ? pen_x[OUT_COORD_BITS-1:0] : '0;
      pix_next.pixel_y       = on_canvas ? pen_y[OUT_COORD_BITS-1:0] : '0;
      pix_next.pixel_ink     = held_ink;
      pix_next.write_enable  = on_canvas;
      pix_next.last_of_point = sts.pen_end;
      pix_next.line_done     = !line_active;
    end else begin
      pix_next.last_of_point = 1'b1;
      pix_next.line_done     = 1'b1;
    end
  end

  // Output register.
  assign out_free = !pix_valid || !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_null) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.emit_null) begin
      pix <= pix_next;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.line_active = line_active;
    sts.pen_end     = (col == pen_last) && (row == pen_last);
    sts.out_free    = out_free;
  end

  `TLR_ASSERT_HOLDS(a_clipped_is_zero, pix_valid && !pix.write_enable, pix.pixel_x == '0 && pix.pixel_y == '0)
  `TLR_ASSERT_HOLDS(a_line_ends_on_update, $fell(line_active), $past(cmd.advance) || $past(cmd.load))

endmodule

// ===== rtl/core/thick_line_rasterizer_core.sv =====
// Top level of the thick line rasterizer: configuration, controller and datapath.
//
// Bresenham line engine with a square pen and canvas clipping. A start word
// (opcode 0) takes the endpoints, ink and pen weight and emits the pen pixels
// of the first point; each step word (opcode 1) advances one major-axis step
// and emits the pen pixels of the new point. A pen of weight 1 is one pixel,
// a weight w above 1 is a square of 2*floor(w/2) pixels on a side, so one
// point gives P = 1 or P = (2*floor(w/2))^2 output words, row by row. The
// single output register writes one pixel word per clock while pix_stall does
// not hold it. Setup of a start word walks difference, absolute value, major
// axis and load through one register stage each, and a step word with no
// active line gives a single word. The next input word is taken as soon as
// the last pixel word of a point sits in the output register. Canvas registers
// lie at byte addresses 0 (width) and 4 (height); the user must write them
// only while the block is idle, and the block itself does not enforce this.
// Pixels off the canvas (negative, or at or beyond its extent) come out with
// write_enable clear and zero coordinates.
module thick_line_rasterizer_core import tlr_pkg::*; #(
  parameter int MAX_WEIGHT = DEF_MAX_WEIGHT,
  parameter int MAX_DIM    = DEF_MAX_DIM
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  req_t                     req,
  output logic                     pix_valid,
  input  logic                     pix_stall,
  output pix_t                     pix,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int EXT_BITS = $clog2(MAX_DIM + 1);
  localparam int PEN_BITS = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1;

  logic [EXT_BITS-1:0] ext_w;
  logic [EXT_BITS-1:0] ext_h;
  cmd_t                cmd;
  sts_t                sts;

  // Canvas registers.
  tlr_cfg #(
    .MAX_DIM  (MAX_DIM),
    .EXT_BITS (EXT_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ext_w   (ext_w),
    .ext_h   (ext_h)
  );

  // Sequencer.
  tlr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and output register.
  tlr_datapath #(
    .MAX_WEIGHT (MAX_WEIGHT),
    .MAX_DIM    (MAX_DIM),
    .EXT_BITS   (EXT_BITS),
    .PEN_BITS   (PEN_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .ext_w     (ext_w),
    .ext_h     (ext_h),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix)
  );

endmodule
